// ===== hdl/abq_pkg.sv =====
package abq_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int SUM_W         = 13;
    localparam int TIMER_W       = 16;
    localparam int LEVEL_W       = 5;
    localparam int HDR_W         = 20;
    localparam int CSUM_IN_W     = 22;
    localparam int S_TDATA_W     = 224;
    localparam int M_TDATA_W     = 184;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd15;

    typedef enum logic [1:0] {
        CMD_MSG  = 2'd0,
        CMD_PKT  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_IDLE    = 3'd0,
        STAT_SEND    = 3'd1,
        STAT_RETX    = 3'd2,
        STAT_QUEUED  = 3'd3,
        STAT_DROPPED = 3'd4,
        STAT_ACKED   = 3'd5,
        STAT_IGNORED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_EMPTY  = 2'd0,
        PH_SUM    = 2'd1,
        PH_DECIDE = 2'd2
    } phase_t;

    // one queued message with its byte sum taken at enqueue time
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [31:0]      high;
        logic [63:0]      mid;
        logic [63:0]      low;
    } qentry_t;

endpackage

// ===== hdl/abq_byte_sum.sv =====
module abq_byte_sum (
    input  logic [abq_pkg::PAYLOAD_W-1:0] payload,
    output logic [abq_pkg::SUM_W-1:0]     sum
);
    import abq_pkg::*;

    localparam int PAIRS = PAYLOAD_BYTES / 2;
    localparam int QUADS = PAIRS / 2;

    logic [8:0]  pair_sum [PAIRS];
    logic [9:0]  quad_sum [QUADS];

    // pairwise adder tree, five partial sums at the last level
    always_comb
    begin
        for (int i = 0; i < PAIRS; i++)
        begin
            pair_sum[i] = {1'b0, payload[16*i +: 8]} + {1'b0, payload[16*i+8 +: 8]};
        end
        for (int j = 0; j < QUADS; j++)
        begin
            quad_sum[j] = {1'b0, pair_sum[2*j]} + {1'b0, pair_sum[2*j+1]};
        end
        sum = {3'b0, quad_sum[0]} + {3'b0, quad_sum[1]} + {3'b0, quad_sum[2]}
            + {3'b0, quad_sum[3]} + {3'b0, quad_sum[4]};
    end

endmodule

// ===== hdl/abq_queue_mem.sv =====
module abq_queue_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  abq_pkg::qentry_t      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output abq_pkg::qentry_t      rdata
);
    import abq_pkg::*;

    qentry_t mem_reg [DEPTH];
    qentry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/alternating_bit_arq_sender.sv =====
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    tdata: payload, in_seq, in_ack, in_checksum; tuser: cmd
// m_*       out  m_tvalid / m_tready    tdata: seq, checksum, payload, queue_level;
//                                       tuser: status, send_valid
// cfg_*     in   cfg_valid / cfg_ready  cfg_data: timeout_ticks
//
// each item passes through the queue memory read and the payload byte sum,
// then through the protocol decision and the state write-back.
// a new item is taken in the decision cycle of the one before it.
// the result sits in an output register; a stalled m_tready holds the
// decision cycle and with it s_tready.
// reset clears pointers, sender state and the timer; the queue memory is not cleared.
module alternating_bit_arq_sender #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // low[63:0], mid[127:64], high[159:128], in_seq[179:160],
    // in_ack[199:180], in_checksum[221:200], zero pad
    input  logic [abq_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_seq[0], out_checksum[13:1], low[77:14], mid[141:78],
    // high[173:142], queue_level[178:174], zero pad
    output logic [abq_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[2:0], send_valid[3]
    output logic [3:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [15:0]                     cfg_data
);
    import abq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // item register
    logic [1:0]           it_cmd_reg;
    logic [PAYLOAD_W-1:0] it_payload_reg;
    logic [HDR_W-1:0]     it_seq_reg;
    logic [HDR_W-1:0]     it_ack_reg;
    logic [CSUM_IN_W-1:0] it_csum_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_comb;

    phase_t phase_reg, phase_next;

    // sender state
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PAYLOAD_W-1:0] cur_payload_reg, cur_payload_next;
    logic                 cur_seq_reg, cur_seq_next;
    logic [SUM_W-1:0]     cur_csum_reg, cur_csum_next;
    logic                 awaiting_reg, awaiting_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic [TIMER_W-1:0]   timeout_reg;
    logic [TIMER_W-1:0]   timer_load;
    logic [TIMER_W-1:0]   timer_dec;

    // output register
    logic                 m_valid_reg;
    status_t              res_status_reg, res_status;
    logic                 res_send_reg, res_send;
    logic [PAYLOAD_W-1:0] res_payload_reg;
    logic                 res_seq_reg;
    logic [SUM_W-1:0]     res_csum_reg;
    logic [LEVEL_W-1:0]   res_level_reg, res_level;
    logic [CNT_W+LEVEL_W-1:0] level_ext;

    logic                 out_free;
    logic                 accept;
    logic                 decide_fire;
    logic                 enq;
    logic [CSUM_IN_W-1:0] pkt_calc;
    qentry_t              q_wdata;
    qentry_t              q_rdata;

    assign out_free    = !m_valid_reg || m_tready;
    assign s_tready    = (phase_reg == PH_EMPTY) || ((phase_reg == PH_DECIDE) && out_free);
    assign accept      = s_tvalid && s_tready;
    assign decide_fire = (phase_reg == PH_DECIDE) && out_free;
    assign cfg_ready   = 1'b1;

    assign timer_load = (timeout_reg == '0) ? TIMER_W'(1) : timeout_reg;
    assign timer_dec  = (timer_reg == '0) ? '0 : timer_reg - TIMER_W'(1);
    assign pkt_calc   = {{(CSUM_IN_W-SUM_W){1'b0}}, sum_reg} + {2'b0, it_seq_reg}
                      + {2'b0, it_ack_reg};

    abq_byte_sum u_sum (
        .payload (it_payload_reg),
        .sum     (sum_comb)
    );

    assign q_wdata.sum  = sum_reg;
    assign q_wdata.high = it_payload_reg[159:128];
    assign q_wdata.mid  = it_payload_reg[127:64];
    assign q_wdata.low  = it_payload_reg[63:0];

    abq_queue_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_queue (
        .clk   (clk),
        .we    (decide_fire && enq),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_EMPTY:
            begin
                if (accept)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase_next = PH_DECIDE;
            end
            PH_DECIDE:
            begin
                if (accept)
                begin
                    phase_next = PH_SUM;
                end
                else if (decide_fire)
                begin
                    phase_next = PH_EMPTY;
                end
            end
            default:
            begin
                phase_next = PH_EMPTY;
            end
        endcase
    end

    // protocol decision for the item in the decide phase
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        cur_payload_next = cur_payload_reg;
        cur_seq_next     = cur_seq_reg;
        cur_csum_next    = cur_csum_reg;
        awaiting_next    = awaiting_reg;
        timer_next       = timer_reg;
        res_status       = STAT_IDLE;
        res_send         = 1'b0;
        enq              = 1'b0;
        case (it_cmd_reg)
            CMD_MSG:
            begin
                if (!awaiting_reg)
                begin
                    cur_payload_next = it_payload_reg;
                    cur_csum_next    = sum_reg + {{(SUM_W-1){1'b0}}, cur_seq_reg};
                    awaiting_next    = 1'b1;
                    timer_next       = timer_load;
                    res_send         = 1'b1;
                    res_status       = STAT_SEND;
                end
                else if (count_reg < CNT_W'(QUEUE_DEPTH))
                begin
                    enq        = 1'b1;
                    tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                               : tail_reg + PTR_W'(1);
                    count_next = count_reg + CNT_W'(1);
                    res_status = STAT_QUEUED;
                end
                else
                begin
                    res_status = STAT_DROPPED;
                end
            end
            CMD_PKT:
            begin
                if (awaiting_reg && (pkt_calc == it_csum_reg)
                    && (it_ack_reg == {{(HDR_W-1){1'b0}}, cur_seq_reg}))
                begin
                    awaiting_next = 1'b0;
                    timer_next    = '0;
                    cur_seq_next  = !cur_seq_reg;
                    res_status    = STAT_ACKED;
                    if (count_reg != '0)
                    begin
                        cur_payload_next = {q_rdata.high, q_rdata.mid, q_rdata.low};
                        cur_csum_next    = q_rdata.sum + {{(SUM_W-1){1'b0}}, !cur_seq_reg};
                        awaiting_next    = 1'b1;
                        timer_next       = timer_load;
                        head_next        = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                         : head_reg + PTR_W'(1);
                        count_next       = count_reg - CNT_W'(1);
                        res_send         = 1'b1;
                    end
                end
                else
                begin
                    res_status = STAT_IGNORED;
                end
            end
            CMD_TICK:
            begin
                if (awaiting_reg)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        timer_next = timer_load;
                        res_send   = 1'b1;
                        res_status = STAT_RETX;
                    end
                end
            end
            default:
            begin
                res_status = STAT_IDLE;
            end
        endcase
    end

    assign level_ext = {{LEVEL_W{1'b0}}, count_next};
    assign res_level = level_ext[LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_EMPTY;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            cur_payload_reg <= '0;
            cur_seq_reg     <= 1'b0;
            cur_csum_reg    <= '0;
            awaiting_reg    <= 1'b0;
            timer_reg       <= '0;
            timeout_reg     <= TIMEOUT_RESET;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (decide_fire)
            begin
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                count_reg       <= count_next;
                cur_payload_reg <= cur_payload_next;
                cur_seq_reg     <= cur_seq_next;
                cur_csum_reg    <= cur_csum_next;
                awaiting_reg    <= awaiting_next;
                timer_reg       <= timer_next;
                m_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_cmd_reg     <= s_tuser;
            it_payload_reg <= s_tdata[PAYLOAD_W-1:0];
            it_seq_reg     <= s_tdata[179:160];
            it_ack_reg     <= s_tdata[199:180];
            it_csum_reg    <= s_tdata[221:200];
        end
        if (phase_reg == PH_SUM)
        begin
            sum_reg <= sum_comb;
        end
        if (decide_fire)
        begin
            res_status_reg  <= res_status;
            res_send_reg    <= res_send;
            res_level_reg   <= res_level;
            // fields read zero when no packet goes out
            res_payload_reg <= res_send ? cur_payload_next : '0;
            res_seq_reg     <= res_send ? cur_seq_next : 1'b0;
            res_csum_reg    <= res_send ? cur_csum_next : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, res_level_reg, res_payload_reg, res_csum_reg, res_seq_reg};
    assign m_tuser  = {res_send_reg, res_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_timer_runs: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg == (timer_reg != '0))
        else $error("timer state disagrees with outstanding packet");

    a_accept_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_reg == PH_SUM))
        else $error("accepted item did not enter the sum phase");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        decide_fire |=> m_valid_reg)
        else $error("decision made without a result");

endmodule

// ===== dv/tb_alternating_bit_arq_sender.sv =====
`timescale 1ns / 100ps

module tb_alternating_bit_arq_sender;

    import abq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PHASE_ITEMS    = 290;
    localparam int NUM_PHASES     = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 50;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [63:0]          low;
        logic [63:0]          mid;
        logic [31:0]          high;
        logic [HDR_W-1:0]     iseq;
        logic [HDR_W-1:0]     iack;
        logic [CSUM_IN_W-1:0] icsum;
    } pkt_item_t;

    typedef struct packed {
        status_t              status;
        logic                 send_valid;
        logic                 seq;
        logic [SUM_W-1:0]     csum;
        logic [63:0]          low;
        logic [63:0]          mid;
        logic [31:0]          high;
        logic [LEVEL_W-1:0]   level;
    } send_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [3:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [15:0]            cfg_data  = '0;

    alternating_bit_arq_sender #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sender model state
    logic [63:0]        q_low [QUEUE_DEPTH];
    logic [63:0]        q_mid [QUEUE_DEPTH];
    logic [31:0]        q_high [QUEUE_DEPTH];
    int                 q_head = 0;
    int                 q_tail = 0;
    int                 q_count = 0;
    logic [63:0]        cur_low = '0;
    logic [63:0]        cur_mid = '0;
    logic [31:0]        cur_high = '0;
    logic               cur_seq = 1'b0;
    logic [SUM_W-1:0]   cur_csum = '0;
    logic               awaiting_ack = 1'b0;
    logic [TIMER_W-1:0] retx_timer = '0;
    logic [TIMER_W-1:0] timeout_reg = TIMEOUT_RESET;

    pkt_item_t    pending_items [$];
    send_result_t expected_results [$];

    int  n_issued = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_cfg_writes = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_requests = 0;
    int  stalls_served = 0;
    int  hold_left = 0;
    logic in_taken = 1'b0;

    function automatic int unsigned payload_sum(logic [63:0] low, logic [63:0] mid,
                                                logic [31:0] high);
        int unsigned s;
        s = 0;
        for (int i = 0; i < 8; i++)
        begin
            s += low[8*i +: 8];
            s += mid[8*i +: 8];
        end
        for (int i = 0; i < 4; i++)
            s += high[8*i +: 8];
        return s;
    endfunction

    function automatic logic [TIMER_W-1:0] timer_reload();
        return (timeout_reg == 0) ? TIMER_W'(1) : timeout_reg;
    endfunction

    task automatic start_packet(logic [63:0] low, logic [63:0] mid, logic [31:0] high);
        cur_low      = low;
        cur_mid      = mid;
        cur_high     = high;
        cur_csum     = SUM_W'(payload_sum(low, mid, high) + cur_seq);
        awaiting_ack = 1'b1;
        retx_timer   = timer_reload();
    endtask

    task automatic emit_packet(inout send_result_t r);
        r.send_valid = 1'b1;
        r.seq        = cur_seq;
        r.csum       = cur_csum;
        r.low        = cur_low;
        r.mid        = cur_mid;
        r.high       = cur_high;
    endtask

    task automatic advance_sender(input pkt_item_t it, output send_result_t r);
        int unsigned calc;
        r = '0;
        r.status = STAT_IDLE;
        case (it.cmd)
            CMD_MSG:
            begin
                if (!awaiting_ack)
                begin
                    start_packet(it.low, it.mid, it.high);
                    emit_packet(r);
                    r.status = STAT_SEND;
                end
                else if (q_count < QUEUE_DEPTH)
                begin
                    q_low[q_tail]  = it.low;
                    q_mid[q_tail]  = it.mid;
                    q_high[q_tail] = it.high;
                    q_tail  = (q_tail + 1) % QUEUE_DEPTH;
                    q_count++;
                    r.status = STAT_QUEUED;
                end
                else
                    r.status = STAT_DROPPED;
            end
            CMD_PKT:
            begin
                calc = payload_sum(it.low, it.mid, it.high) + it.iseq + it.iack;
                if (awaiting_ack && calc == it.icsum && it.iack == HDR_W'(cur_seq))
                begin
                    awaiting_ack = 1'b0;
                    retx_timer   = '0;
                    cur_seq      = ~cur_seq;
                    r.status     = STAT_ACKED;
                    if (q_count > 0)
                    begin
                        start_packet(q_low[q_head], q_mid[q_head], q_high[q_head]);
                        q_head = (q_head + 1) % QUEUE_DEPTH;
                        q_count--;
                        emit_packet(r);
                    end
                end
                else
                    r.status = STAT_IGNORED;
            end
            CMD_TICK:
            begin
                if (awaiting_ack)
                begin
                    if (retx_timer > 0)
                        retx_timer--;
                    if (retx_timer == 0)
                    begin
                        retx_timer = timer_reload();
                        emit_packet(r);
                        r.status = STAT_RETX;
                    end
                end
            end
            default: ;
        endcase
        r.level = LEVEL_W'(q_count);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
                     n_results, field, got, want);
        error_count++;
    endtask

    task automatic check_result(send_result_t got, send_result_t want);
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.send_valid != want.send_valid)
            report_mismatch("send_valid", got.send_valid, want.send_valid);
        if (got.seq != want.seq)
            report_mismatch("out_seq", got.seq, want.seq);
        if (got.csum != want.csum)
            report_mismatch("out_checksum", got.csum, want.csum);
        if (got.low != want.low)
            report_mismatch("out_payload_low", got.low, want.low);
        if (got.mid != want.mid)
            report_mismatch("out_payload_mid", got.mid, want.mid);
        if (got.high != want.high)
            report_mismatch("out_payload_high", got.high, want.high);
        if (got.level != want.level)
            report_mismatch("queue_level", got.level, want.level);
    endtask

    // input and config transfers feed the model, output transfers are checked
    always @(posedge clk)
    begin : monitor
        pkt_item_t    it;
        send_result_t got;
        send_result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                it.cmd   = s_tuser;
                it.low   = s_tdata[63:0];
                it.mid   = s_tdata[127:64];
                it.high  = s_tdata[159:128];
                it.iseq  = s_tdata[179:160];
                it.iack  = s_tdata[199:180];
                it.icsum = s_tdata[221:200];
                advance_sender(it, want);
                expected_results.push_back(want);
                n_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg = cfg_data;
                n_cfg_writes++;
            end
            if (m_tvalid && m_tready)
            begin
                got.status     = status_t'(m_tuser[2:0]);
                got.send_valid = m_tuser[3];
                got.seq        = m_tdata[0];
                got.csum       = m_tdata[13:1];
                got.low        = m_tdata[77:14];
                got.mid        = m_tdata[141:78];
                got.high       = m_tdata[173:142];
                got.level      = m_tdata[178:174];
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", m_tuser, '0);
                else
                    check_result(got, expected_results.pop_front());
                n_results++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        pkt_item_t it;
        if (!s_tvalid || in_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, it.icsum, it.iack, it.iseq, it.high, it.mid, it.low};
                s_tuser  <= it.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_requests != stalls_served)
        begin
            stalls_served = stall_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic pkt_item_t make_item(logic [1:0] cmd, logic [63:0] low,
                                            logic [63:0] mid, logic [31:0] high,
                                            logic [HDR_W-1:0] iseq, logic [HDR_W-1:0] iack,
                                            logic [CSUM_IN_W-1:0] icsum);
        pkt_item_t it;
        it.cmd   = cmd;
        it.low   = low;
        it.mid   = mid;
        it.high  = high;
        it.iseq  = iseq;
        it.iack  = iack;
        it.icsum = icsum;
        return it;
    endfunction

    // network packet whose checksum field matches its contents
    function automatic pkt_item_t ack_packet(logic [63:0] low, logic [63:0] mid,
                                             logic [31:0] high, logic [HDR_W-1:0] iseq,
                                             logic [HDR_W-1:0] iack);
        return make_item(CMD_PKT, low, mid, high, iseq, iack,
                         CSUM_IN_W'(payload_sum(low, mid, high) + iseq + iack));
    endfunction

    function automatic pkt_item_t noise_item(logic [1:0] cmd);
        return make_item(cmd, rand64(), rand64(), $urandom(), HDR_W'($urandom()),
                         HDR_W'($urandom()), CSUM_IN_W'($urandom()));
    endfunction

    task automatic queue_item(pkt_item_t it);
        pending_items.push_back(it);
        n_issued++;
    endtask

    function automatic pkt_item_t message_item();
        pkt_item_t it;
        int        pick;
        it = noise_item(CMD_MSG);
        pick = $urandom_range(19);
        if (pick == 0)
            {it.low, it.mid, it.high} = '1;
        else if (pick == 1)
            {it.low, it.mid, it.high} = '0;
        return it;
    endfunction

    task automatic add_random_items(int count, int msg_weight);
        int        added;
        int        pick;
        int        burst;
        pkt_item_t it;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < msg_weight)
            begin
                queue_item(message_item());
                added++;
            end
            else if (pick < msg_weight + 30)
            begin
                // well-formed ack, ack bit right or wrong depending on state
                queue_item(ack_packet(rand64(), rand64(), $urandom(), HDR_W'($urandom()),
                                      HDR_W'($urandom_range(1))));
                added++;
            end
            else if (pick < msg_weight + 35)
            begin
                queue_item(noise_item(CMD_PKT));
                added++;
            end
            else if (pick < msg_weight + 40)
            begin
                it = ack_packet(rand64(), rand64(), $urandom(), HDR_W'($urandom()),
                                HDR_W'($urandom_range(1)));
                if ($urandom_range(1))
                    it.icsum ^= CSUM_IN_W'(1) << $urandom_range(CSUM_IN_W - 1);
                else
                    it = ack_packet(it.low, it.mid, it.high, it.iseq,
                                    HDR_W'($urandom_range(2, 2**HDR_W - 1)));
                queue_item(it);
                added++;
            end
            else if (pick < msg_weight + 43)
            begin
                queue_item(noise_item(CMD_NONE));
                added++;
            end
            else
            begin
                burst = (pick < msg_weight + 50) ? 1 : $urandom_range(2, 12);
                repeat (burst)
                    queue_item(noise_item(CMD_TICK));
                added += burst;
            end
        end
    endtask

    task automatic wait_until_drained();
        while (n_accepted != n_issued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        int writes_seen;
        writes_seen = n_cfg_writes;
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (n_cfg_writes == writes_seen);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [63:0] ones64;
        logic [31:0] ones32;
        logic [15:0] timeouts [NUM_PHASES];
        ones64 = '1;
        ones32 = '1;
        timeouts = '{16'd0, 16'd1, 16'hFFFF, 16'd0, TIMEOUT_RESET, 16'd3};
        timeouts[3] = 16'($urandom_range(2, 40));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        send_idle_pct = 11;
        recv_idle_pct = 80;
        // nothing outstanding: tick, unused command and a clean ack all do nothing
        queue_item(noise_item(CMD_TICK));
        queue_item(noise_item(CMD_NONE));
        queue_item(ack_packet(rand64(), rand64(), $urandom(), '0, '0));
        // first message goes out at once, the next two wait in the queue
        queue_item(make_item(CMD_MSG, '0, '0, '0, '0, '0, '0));
        queue_item(make_item(CMD_MSG, ones64, ones64, ones32, '1, '1, '1));
        queue_item(message_item());
        // bad checksum, then a good checksum with the wrong ack number
        queue_item(make_item(CMD_PKT, ones64, ones64, ones32, '1, '1, '1));
        queue_item(ack_packet(ones64, ones64, ones32, '1, '1));
        // acks that pull the queued messages out
        queue_item(ack_packet(ones64, ones64, ones32, '1, '0));
        queue_item(noise_item(CMD_TICK));
        queue_item(noise_item(CMD_TICK));
        queue_item(ack_packet(rand64(), rand64(), $urandom(), '0, HDR_W'(1)));
        // ack with an empty queue sends nothing
        queue_item(ack_packet(rand64(), rand64(), $urandom(), HDR_W'($urandom()), '0));
        queue_item(message_item());
        queue_item(ack_packet(rand64(), rand64(), $urandom(), HDR_W'($urandom()), '0));
        queue_item(ack_packet(rand64(), rand64(), $urandom(), HDR_W'($urandom()),
                              HDR_W'(1)));
        wait_until_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_timeout(timeouts[ph]);
            @(posedge clk);
            if (ph < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 80;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            add_random_items(PHASE_ITEMS, (ph % 2 == 0) ? 40 : 20);
            // long receiver hold while the sender keeps offering
            if (ph == 4)
                stall_requests++;
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
